/* rtl/bet_pkg.sv */
// Shared types and codes for the balanced event table.
package bet_pkg;

   localparam int KEY_W = 64;
   localparam int LEN_W = 8;
   localparam int CNT_W32 = 32;
   localparam int PROB_W = 17;
   localparam int GAIN_W = 16;
   localparam int DRAW_W = 16;

   localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
   localparam logic [CNT_W32-1:0] CNT_MAX = 32'hFFFF_FFFF;

   localparam logic [1:0] CMD_PRESENT = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   localparam logic [1:0] REG_TARGET = 2'd0;
   localparam logic [1:0] REG_GAIN = 2'd1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
      logic [CNT_W32-1:0] events;
      logic [CNT_W32-1:0] presentations;
   } entry_type;

   typedef struct packed {
      logic start;
      logic [CNT_W32-1:0] events;
      logic [CNT_W32-1:0] presentations;
      logic [PROB_W-1:0] target;
      logic [GAIN_W-1:0] gain;
   } calc_req_type;

   typedef struct packed {
      logic done;
      logic [PROB_W-1:0] prob;
   } calc_rsp_type;

endpackage

/* rtl/bet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bet_calc.sv */
// Iterative probability correction unit: restoring divider, one multiply, clamp.
module bet_calc import bet_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  calc_req_type req,
   output calc_rsp_type rsp
);

   localparam logic [2:0] C_IDLE = 3'd0;
   localparam logic [2:0] C_DIV = 3'd1;
   localparam logic [2:0] C_MUL = 3'd2;
   localparam logic [2:0] C_SGN = 3'd3;
   localparam logic [2:0] C_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [16:0] quo_ff, quo_in;
   logic [3:0] step_ff, step_in;
   logic [16:0] p_ff, p_in;
   logic [15:0] gain_ff, gain_in;
   logic [32:0] prod_ff, prod_in;
   logic neg_ff, neg_in;
   logic [16:0] q_ff, q_in;

   logic [32:0] trial;
   logic [17:0] err;
   logic [16:0] err_abs;
   logic [22:0] q_wide;

   always_comb begin
      state_in = state_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      p_in = p_ff;
      gain_in = gain_ff;
      prod_in = prod_ff;
      neg_in = neg_ff;
      q_in = q_ff;
      trial = {rem_ff, 1'b0} - {1'b0, div_ff};
      err = {1'b0, quo_ff} - {1'b0, p_ff};
      err_abs = err[17] ? 17'(-err) : err[16:0];
      q_wide = neg_ff ? ({6'd0, p_ff} + {2'd0, prod_ff[32:12]})
                      : ({6'd0, p_ff} - {2'd0, prod_ff[32:12]});
      unique case (state_ff)
         C_IDLE: begin
            if (req.start) begin
               p_in = req.target;
               gain_in = req.gain;
               div_in = req.presentations;
               rem_in = req.events;
               quo_in = '0;
               step_in = '0;
               if (req.presentations == '0) begin
                  q_in = req.target;
                  state_in = C_DONE;
               end else if (req.events >= req.presentations) begin
                  quo_in = ONE_Q16;
                  state_in = C_MUL;
               end else begin
                  state_in = C_DIV;
               end
            end
         end
         C_DIV: begin
            // One quotient bit per cycle; the remainder stays below the divisor.
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], 1'b0};
               quo_in = {quo_ff[15:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            prod_in = 33'(gain_ff * err_abs);
            neg_in = err[17];
            state_in = C_SGN;
         end
         C_SGN: begin
            if (q_wide[22]) begin
               q_in = '0;
            end else if (q_wide > 23'(ONE_Q16)) begin
               q_in = ONE_Q16;
            end else begin
               q_in = q_wide[16:0];
            end
            state_in = C_DONE;
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
      p_ff <= p_in;
      gain_ff <= gain_in;
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      q_ff <= q_in;
   end

   assign rsp.done = (state_ff == C_DONE);
   assign rsp.prob = q_ff;

endmodule

/* rtl/balanced_event_table.sv */
// Top level of the balanced event table: sequencer, entry memory and result register.
//
// The request channel (req_valid/req_ready) carries one command per transfer:
// present, query, remove or clear, with the label key, its full length and a
// random draw. The response channel (rsp_valid/rsp_ready) returns one result
// per command. Configuration registers are written through csr_we/csr_index/
// csr_wdata and should only change while the block is idle.
// A command walks the entry memory one slot at a time (read, then compare),
// and a presentation then runs the shared correction unit: up to 16 divider
// steps plus multiply and clamp. A clear skips the walk. The block accepts
// one command at a time and raises req_ready again once its result sits in
// the output register, even if the receiver has not taken it yet.
// Reset empties the table, clears both sticky flags and restores the default
// registers; memory contents are left as they are. If the receiver stalls,
// the finished result is held and the next result waits in the sequencer.
module balanced_event_table import bet_pkg::*; #(
   parameter int CAPACITY = 16,
   parameter int KEY_BYTES = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_cmd,
   input  logic [63:0] req_label_key,
   input  logic [7:0] req_name_length,
   input  logic [15:0] req_draw,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_event_res,
   output logic [1:0] rsp_status,
   output logic [31:0] rsp_event_count,
   output logic [31:0] rsp_presentation_count,
   output logic [4:0] rsp_entries_used,
   output logic rsp_overflow_seen,
   output logic rsp_truncation_seen,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int USE_W = $clog2(CAPACITY + 1);
   localparam logic [USE_W-1:0] CAP_VAL = USE_W'(CAPACITY);
   localparam logic [LEN_W-1:0] KEY_BYTES_VAL = LEN_W'(KEY_BYTES);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD = 4'd1;
   localparam logic [3:0] S_CMP = 4'd2;
   localparam logic [3:0] S_MISS = 4'd3;
   localparam logic [3:0] S_CALC = 4'd4;
   localparam logic [3:0] S_RDLAST = 4'd5;
   localparam logic [3:0] S_MOVE = 4'd6;
   localparam logic [3:0] S_DONE = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [63:0] key_ff, key_in;
   logic [7:0] len_ff, len_in;
   logic [15:0] draw_ff, draw_in;
   logic [USE_W-1:0] idx_ff, idx_in;
   logic [USE_W-1:0] used_ff, used_in;
   logic ovf_ff, ovf_in;
   logic trunc_ff, trunc_in;
   logic [31:0] ev_ff, ev_in;
   logic [31:0] pr_ff, pr_in;
   logic [16:0] target_ff, target_in;
   logic [15:0] gain_ff, gain_in;
   logic res_fire_ff, res_fire_in;
   logic [1:0] res_status_ff, res_status_in;
   logic [31:0] res_ev_ff, res_ev_in;
   logic [31:0] res_pr_ff, res_pr_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic out_fire_ff, out_fire_in;
   logic [1:0] out_status_ff, out_status_in;
   logic [31:0] out_ev_ff, out_ev_in;
   logic [31:0] out_pr_ff, out_pr_in;
   logic [4:0] out_used_ff, out_used_in;
   logic out_ovf_ff, out_ovf_in;
   logic out_trunc_ff, out_trunc_in;

   logic [63:0] masked_key;
   logic [16:0] p_eff;
   logic [USE_W-1:0] last_idx;
   logic accept;
   logic fire_now;
   logic [31:0] pr_next;
   logic [31:0] ev_next;

   logic ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [IDX_W-1:0] ram_raddr;
   entry_type ram_wdata;
   entry_type ram_rdata;

   logic calc_start;
   calc_req_type calc_req;
   calc_rsp_type calc_rsp;

   // Only the first min(length, KEY_BYTES) bytes of a name identify it.
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         masked_key[8*b +: 8] = (b < KEY_BYTES && LEN_W'(b) < req_name_length) ?
                                req_label_key[8*b +: 8] : 8'd0;
      end
   end

   assign p_eff = (target_ff > ONE_Q16) ? ONE_Q16 : target_ff;
   assign last_idx = used_ff - USE_W'(1);
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   assign fire_now = {1'b0, draw_ff} < calc_rsp.prob;
   assign pr_next = (pr_ff == CNT_MAX) ? pr_ff : pr_ff + 32'd1;
   assign ev_next = (fire_now && ev_ff != CNT_MAX) ? ev_ff + 32'd1 : ev_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      len_in = len_ff;
      draw_in = draw_ff;
      idx_in = idx_ff;
      used_in = used_ff;
      ovf_in = ovf_ff;
      trunc_in = trunc_ff;
      ev_in = ev_ff;
      pr_in = pr_ff;
      res_fire_in = res_fire_ff;
      res_status_in = res_status_ff;
      res_ev_in = res_ev_ff;
      res_pr_in = res_pr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_fire_in = out_fire_ff;
      out_status_in = out_status_ff;
      out_ev_in = out_ev_ff;
      out_pr_in = out_pr_ff;
      out_used_in = out_used_ff;
      out_ovf_in = out_ovf_ff;
      out_trunc_in = out_trunc_ff;
      calc_start = 1'b0;
      ram_we = 1'b0;
      ram_waddr = idx_ff[IDX_W-1:0];
      ram_wdata = '{key: key_ff, len: len_ff, events: ev_next, presentations: pr_next};
      ram_raddr = (state_ff == S_RDLAST) ? last_idx[IDX_W-1:0] : idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               key_in = masked_key;
               len_in = req_name_length;
               draw_in = req_draw;
               idx_in = '0;
               res_fire_in = 1'b0;
               res_status_in = ST_OK;
               res_ev_in = '0;
               res_pr_in = '0;
               if (req_cmd == CMD_CLEAR) begin
                  used_in = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = (idx_ff < used_ff) ? S_CMP : S_MISS;
         end
         S_CMP: begin
            if (ram_rdata.len == len_ff && ram_rdata.key == key_ff) begin
               ev_in = ram_rdata.events;
               pr_in = ram_rdata.presentations;
               unique case (cmd_ff)
                  CMD_PRESENT: begin
                     calc_start = 1'b1;
                     state_in = S_CALC;
                  end
                  CMD_QUERY: begin
                     res_ev_in = ram_rdata.events;
                     res_pr_in = ram_rdata.presentations;
                     state_in = S_DONE;
                  end
                  CMD_REMOVE: begin
                     if (idx_ff == last_idx) begin
                        used_in = last_idx;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_RDLAST;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end else begin
               idx_in = idx_ff + USE_W'(1);
               state_in = S_RD;
            end
         end
         S_MISS: begin
            if (cmd_ff == CMD_PRESENT) begin
               if (used_ff >= CAP_VAL) begin
                  ovf_in = 1'b1;
                  res_status_in = ST_FULL;
                  res_fire_in = {1'b0, draw_ff} < p_eff;
                  state_in = S_DONE;
               end else begin
                  // New label takes the next free slot with zero counts.
                  idx_in = used_ff;
                  ev_in = '0;
                  pr_in = '0;
                  if (len_ff > KEY_BYTES_VAL) begin
                     trunc_in = 1'b1;
                  end
                  used_in = used_ff + USE_W'(1);
                  calc_start = 1'b1;
                  state_in = S_CALC;
               end
            end else begin
               res_status_in = ST_MISSING;
               state_in = S_DONE;
            end
         end
         S_CALC: begin
            if (calc_rsp.done) begin
               ram_we = 1'b1;
               res_fire_in = fire_now;
               res_ev_in = ev_next;
               res_pr_in = pr_next;
               state_in = S_DONE;
            end
         end
         S_RDLAST: begin
            state_in = S_MOVE;
         end
         S_MOVE: begin
            // The last entry fills the hole left by the removed label.
            ram_we = 1'b1;
            ram_wdata = ram_rdata;
            used_in = last_idx;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_fire_in = res_fire_ff;
               out_status_in = res_status_ff;
               out_ev_in = res_ev_ff;
               out_pr_in = res_pr_ff;
               out_used_in = 5'(used_ff);
               out_ovf_in = ovf_ff;
               out_trunc_in = trunc_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      target_in = target_ff;
      gain_in = gain_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_TARGET: target_in = csr_wdata;
            REG_GAIN: gain_in = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign calc_req.start = calc_start;
   assign calc_req.events = ev_in;
   assign calc_req.presentations = pr_in;
   assign calc_req.target = p_eff;
   assign calc_req.gain = gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         ovf_ff <= 1'b0;
         trunc_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff <= 17'd32768;
         gain_ff <= 16'd4096;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         ovf_ff <= ovf_in;
         trunc_ff <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff <= target_in;
         gain_ff <= gain_in;
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      len_ff <= len_in;
      draw_ff <= draw_in;
      idx_ff <= idx_in;
      ev_ff <= ev_in;
      pr_ff <= pr_in;
      res_fire_ff <= res_fire_in;
      res_status_ff <= res_status_in;
      res_ev_ff <= res_ev_in;
      res_pr_ff <= res_pr_in;
      out_fire_ff <= out_fire_in;
      out_status_ff <= out_status_in;
      out_ev_ff <= out_ev_in;
      out_pr_ff <= out_pr_in;
      out_used_ff <= out_used_in;
      out_ovf_ff <= out_ovf_in;
      out_trunc_ff <= out_trunc_in;
   end

   bet_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   bet_calc u_calc (
      .clock(clock),
      .reset(reset),
      .req(calc_req),
      .rsp(calc_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_res = out_fire_ff;
   assign rsp_status = out_status_ff;
   assign rsp_event_count = out_ev_ff;
   assign rsp_presentation_count = out_pr_ff;
   assign rsp_entries_used = out_used_ff;
   assign rsp_overflow_seen = out_ovf_ff;
   assign rsp_truncation_seen = out_trunc_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CAP_VAL)
      else $error("table fill exceeds capacity");
   a_calc_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      calc_rsp.done |-> state_ff == S_CALC)
      else $error("correction finished outside a presentation");
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag dropped");
   a_trunc_sticky: assert property (@(posedge clock) disable iff (reset)
      trunc_ff |=> trunc_ff)
      else $error("truncation flag dropped");
`endif

endmodule

/* verif/tb_balanced_event_table.sv */
// Self-checking testbench for the balanced event table.
`timescale 1ns / 1ps

module tb_balanced_event_table;
   import bet_pkg::*;

   // Index that maps to no register; a write there must change nothing.
   localparam logic [1:0] REG_NONE = 2'd3;
   localparam int TABLE_DEPTH = 16;
   localparam int POOL_SIZE = 24;
   localparam int RANDOM_ITEMS = 700;
   // Worst command is a full lookup plus the divider.
   localparam int SETTLE_CYCLES = 120;

   // One command as the request channel carries it.
   typedef struct {
      logic [1:0] cmd;
      logic [63:0] key;
      logic [7:0] len;
      logic [15:0] draw;
   } command_type;

   // One result as the response channel carries it.
   typedef struct {
      logic fire;
      logic [1:0] status;
      logic [31:0] events;
      logic [31:0] shows;
      logic [4:0] used;
      logic overflow;
      logic truncated;
   } outcome_type;

   // The scoreboard keeps its own copy of the table and the registers,
   // predicts the outcome of every accepted command and checks the
   // responses against those predictions in order.
   class event_table_scoreboard;
      logic [63:0] keys[TABLE_DEPTH];
      logic [7:0] lens[TABLE_DEPTH];
      logic [31:0] events[TABLE_DEPTH];
      logic [31:0] shows[TABLE_DEPTH];
      int used;
      logic overflow;
      logic truncated;
      logic [16:0] target;
      logic [15:0] gain;
      outcome_type expected_outcomes[$];
      int errors;

      function new();
         used = 0;
         overflow = 0;
         truncated = 0;
         target = 17'd32768;
         gain = 16'd4096;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [16:0] value);
         if (idx == REG_TARGET) target = value;
         else if (idx == REG_GAIN) gain = value[15:0];
      endfunction

      function logic [63:0] prefix(logic [63:0] key, logic [7:0] len);
         logic [63:0] mask;
         mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
         return key & mask;
      endfunction

      function int find(logic [63:0] key, logic [7:0] len);
         for (int i = 0; i < used; i++)
            if (lens[i] == len && keys[i] == prefix(key, len)) return i;
         return -1;
      endfunction

      function longint clipped_target();
         return (target > ONE_Q16) ? longint'(ONE_Q16) : longint'(target);
      endfunction

      // Probability after the feedback correction, Q1.16.
      function longint corrected(logic [31:0] ev, logic [31:0] pr);
         longint p, obs, err, mag, q;
         p = clipped_target();
         if (pr == 0) return p;
         obs = ({ev, 16'd0}) / pr;
         if (obs > 65536) obs = 65536;
         err = obs - p;
         mag = (longint'(gain) * (err < 0 ? -err : err)) >>> 12;
         q = p - (err < 0 ? -mag : mag);
         if (q < 0) q = 0;
         if (q > 65536) q = 65536;
         return q;
      endfunction

      function void note(command_type c);
         outcome_type o;
         int slot;
         o = '{default: '0};
         slot = find(c.key, c.len);
         if (c.cmd == CMD_PRESENT) begin
            if (slot < 0 && used >= TABLE_DEPTH) begin
               overflow = 1;
               o.status = ST_FULL;
               o.fire = longint'(c.draw) < clipped_target();
            end else begin
               longint q;
               if (slot < 0) begin
                  slot = used;
                  keys[slot] = prefix(c.key, c.len);
                  lens[slot] = c.len;
                  events[slot] = 0;
                  shows[slot] = 0;
                  if (c.len > 8) truncated = 1;
                  used++;
               end
               q = corrected(events[slot], shows[slot]);
               if (shows[slot] != CNT_MAX) shows[slot]++;
               if (longint'(c.draw) < q) begin
                  o.fire = 1;
                  if (events[slot] != CNT_MAX) events[slot]++;
               end
               o.events = events[slot];
               o.shows = shows[slot];
            end
         end else if (c.cmd == CMD_QUERY) begin
            if (slot < 0) o.status = ST_MISSING;
            else begin
               o.events = events[slot];
               o.shows = shows[slot];
            end
         end else if (c.cmd == CMD_REMOVE) begin
            if (slot < 0) o.status = ST_MISSING;
            else begin
               // The last entry moves into the freed slot.
               keys[slot] = keys[used-1];
               lens[slot] = lens[used-1];
               events[slot] = events[used-1];
               shows[slot] = shows[used-1];
               used--;
            end
         end else begin
            used = 0;
         end
         o.used = used[4:0];
         o.overflow = overflow;
         o.truncated = truncated;
         expected_outcomes.push_back(o);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check(outcome_type got);
         outcome_type e;
         if (expected_outcomes.size() == 0) begin
            report("response with no command outstanding");
            return;
         end
         e = expected_outcomes.pop_front();
         if (got.fire !== e.fire)
            report($sformatf("event_res %0b, expected %0b", got.fire, e.fire));
         if (got.status !== e.status)
            report($sformatf("status %0d, expected %0d", got.status, e.status));
         if (got.events !== e.events)
            report($sformatf("event_count %0d, expected %0d", got.events, e.events));
         if (got.shows !== e.shows)
            report($sformatf("presentation_count %0d, expected %0d", got.shows, e.shows));
         if (got.used !== e.used)
            report($sformatf("entries_used %0d, expected %0d", got.used, e.used));
         if (got.overflow !== e.overflow)
            report($sformatf("overflow_seen %0b, expected %0b", got.overflow, e.overflow));
         if (got.truncated !== e.truncated)
            report($sformatf("truncation_seen %0b, expected %0b", got.truncated,
                             e.truncated));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_cmd = CMD_CLEAR;
   logic [63:0] req_label_key = '0;
   logic [7:0] req_name_length = '0;
   logic [15:0] req_draw = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_event_res;
   logic [1:0] rsp_status;
   logic [31:0] rsp_event_count;
   logic [31:0] rsp_presentation_count;
   logic [4:0] rsp_entries_used;
   logic rsp_overflow_seen;
   logic rsp_truncation_seen;
   logic csr_we = 0;
   logic [1:0] csr_index = REG_TARGET;
   logic [16:0] csr_wdata = '0;

   // When this is low neither side idles, giving back-to-back transfers.
   logic gaps_on = 1;

   event_table_scoreboard board = new();

   // A fixed set of labels used by the random part so that presents hit
   // known entries, the table fills up and removes find their target.
   command_type label_pool[POOL_SIZE];

   balanced_event_table dut (.*);

   always #4 clock = ~clock;

   // Response side: take a transfer whenever valid and ready meet, and
   // stall at random for roughly one cycle in eight.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check('{rsp_event_res, rsp_status, rsp_event_count,
                       rsp_presentation_count, rsp_entries_used,
                       rsp_overflow_seen, rsp_truncation_seen});
      rsp_ready <= !(gaps_on && $urandom_range(99) < 12);
   end

   // Generous ceiling: far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   // Drives one command and waits for its transfer. Called at a clock edge.
   task automatic send(logic [1:0] cmd, logic [63:0] key, logic [7:0] len,
                       logic [15:0] draw);
      while (gaps_on && $urandom_range(99) < 12) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_label_key <= key;
      req_name_length <= len;
      req_draw <= draw;
      do @(posedge clock); while (!req_ready);
      board.note('{cmd, key, len, draw});
   endtask

   // Waits until every predicted response has come back, then lets the
   // block settle so that register writes only land while it is idle.
   task automatic drain();
      req_valid <= 0;
      while (board.expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [16:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      board.write_reg(idx, value);
   endtask

   // Random command over the label pool; about one in ten uses a fresh,
   // unrelated label as noise. Bits above a short label's prefix are
   // randomized since the block must ignore them.
   task automatic random_command();
      command_type c;
      int pick;
      c = label_pool[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(9) == 0) begin
         c.key = {$urandom, $urandom};
         c.len = 8'($urandom_range(255));
      end else if (c.len < 8) begin
         c.key = board.prefix(c.key, c.len) |
                 ({$urandom, $urandom} & ~board.prefix('1, c.len));
      end
      pick = $urandom_range(99);
      if (pick < 70) c.cmd = CMD_PRESENT;
      else if (pick < 84) c.cmd = CMD_QUERY;
      else if (pick < 98) c.cmd = CMD_REMOVE;
      else c.cmd = CMD_CLEAR;
      send(c.cmd, c.key, c.len, 16'($urandom_range(65535)));
   endtask

   initial begin
      logic [16:0] targets[6];
      logic [15:0] gains[6];
      logic [63:0] k;

      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part under the reset register values.
      k = 64'h0123_4567_89AB_CDEF;
      send(CMD_PRESENT, '1, 8'd0, 16'd0);         // empty name, draw at zero
      send(CMD_PRESENT, k, 8'd3, 16'hFFFF);       // short name, top draw
      send(CMD_PRESENT, k, 8'd8, 16'd32767);
      send(CMD_PRESENT, k, 8'd9, 16'd32768);      // longer than the stored key
      send(CMD_PRESENT, k, 8'd10, 16'd100);       // same prefix, other length
      send(CMD_PRESENT, '1, 8'd255, 16'd0);
      send(CMD_PRESENT, k, 8'd3, 16'd0);          // known label, corrected
      send(CMD_PRESENT, k, 8'd3, 16'd40000);
      send(CMD_QUERY, k, 8'd9, 16'd0);
      send(CMD_QUERY, k, 8'd11, 16'd0);           // unknown label
      send(CMD_REMOVE, 64'h55, 8'd1, 16'd0);      // unknown label
      send(CMD_REMOVE, k, 8'd8, 16'd0);           // last entry fills the hole
      send(CMD_QUERY, '1, 8'd255, 16'd0);
      send(CMD_CLEAR, '0, 8'd0, 16'd0);
      // Fill the table, then meet it with a new label.
      for (int i = 0; i < TABLE_DEPTH; i++)
         send(CMD_PRESENT, 64'hA000 + i, 8'd2, 16'(i * 4000));
      send(CMD_PRESENT, 64'hBEEF, 8'd2, 16'd1000);
      drain();

      // Register settings per phase: extremes first, a target above one, a
      // quarter target with full gain, then random values.
      targets = '{17'd0, 17'd65536, 17'h1FFFF, 17'd16384, 17'd0, 17'd0};
      gains = '{16'hFFFF, 16'd0, 16'd4096, 16'hFFFF, 16'd0, 16'd0};
      for (int i = 0; i < POOL_SIZE; i++) begin
         label_pool[i].key = {$urandom, $urandom};
         label_pool[i].len = (i < 18) ? 8'($urandom_range(12)) : 8'($urandom_range(255));
      end

      for (int phase = 0; phase < 6; phase++) begin
         if (phase >= 4) begin
            targets[phase] = 17'($urandom_range(65536));
            gains[phase] = 16'($urandom_range(16384));
         end
         write_reg(REG_TARGET, targets[phase]);
         write_reg(REG_GAIN, gains[phase]);
         write_reg(REG_NONE, 17'($urandom));
         // Phase three runs without any idling on either side.
         gaps_on <= (phase != 3);
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) random_command();
         drain();
      end

      if (board.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
